### src/prao_pkg.sv
// Shared types and constants for the part rotation and offset pipeline.
// Depends on nothing; every other file in src imports it.
`default_nettype none

package prao_pkg;

    // Fraction bits of the 4.12 fixed-point format.
    localparam int unsigned FRAC_BITS = 12;

    // Bit range that holds a product floored by 2^12 and wrapped to 16 bits.
    localparam int unsigned PROD_LSB = FRAC_BITS;
    localparam int unsigned PROD_MSB = FRAC_BITS + 15;

    // Bias added to a negative value so the shift truncates toward zero.
    localparam logic [31:0] TRUNC_BIAS = 32'd4095;

    // Load enables for the four register stages of the pipeline.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } stage_en_t;

endpackage

`default_nettype wire

### src/prao_offset_pipe.sv
// Four-stage datapath for the scaled x and y part offsets.
// Depends on prao_pkg for the stage enables and fixed-point constants.
`default_nettype none

module prao_offset_pipe
    import prao_pkg::*;
(
    input  wire                aclk,
    input  wire stage_en_t     stage_en,
    input  wire  [15:0]        offset_pair,
    input  wire  signed [15:0] actor_scale,
    input  wire  [4:0]         ofs_shift,
    input  wire                mirror_x,
    input  wire                part_en_s3,
    output logic signed [19:0] disp_x,
    output logic signed [19:0] disp_y
);

    logic [31:0]        x_shift_next;
    logic [31:0]        y_shift_next;
    logic [31:0]        x_shift_reg;
    logic [31:0]        y_shift_reg;
    logic signed [15:0] scale_reg;

    logic signed [47:0] x_mul;
    logic signed [47:0] y_mul;
    logic [31:0]        x_prod_reg;
    logic [31:0]        y_prod_reg;

    logic [31:0]        x_biased;
    logic [31:0]        y_biased;
    logic [19:0]        x_trunc_reg;
    logic [19:0]        y_trunc_reg;

    logic [19:0]        disp_x_reg;
    logic [19:0]        disp_y_reg;

    // Stage 1: sign-extend each byte, shift it left, negate x on mirror.
    always_comb begin
        logic [31:0] xs;
        xs = {{24{offset_pair[7]}}, offset_pair[7:0]} << ofs_shift;
        x_shift_next = mirror_x ? 32'(32'd0 - xs) : xs;
        y_shift_next = {{24{offset_pair[15]}}, offset_pair[15:8]} << ofs_shift;
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld1) begin
            x_shift_reg <= x_shift_next;
            y_shift_reg <= y_shift_next;
            scale_reg   <= actor_scale;
        end
    end

    // Stage 2: multiply by the scale and keep the low 32 bits.
    assign x_mul = $signed(x_shift_reg) * scale_reg;
    assign y_mul = $signed(y_shift_reg) * scale_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.ld2) begin
            x_prod_reg <= x_mul[31:0];
            y_prod_reg <= y_mul[31:0];
        end
    end

    // Stage 3: divide by 4096 rounding toward zero.
    assign x_biased = x_prod_reg + (x_prod_reg[31] ? TRUNC_BIAS : 32'd0);
    assign y_biased = y_prod_reg + (y_prod_reg[31] ? TRUNC_BIAS : 32'd0);

    always_ff @(posedge aclk) begin
        if (stage_en.ld3) begin
            x_trunc_reg <= x_biased[31:FRAC_BITS];
            y_trunc_reg <= y_biased[31:FRAC_BITS];
        end
    end

    // Stage 4: output register, zero for a disabled part.
    always_ff @(posedge aclk) begin
        if (stage_en.ld4) begin
            disp_x_reg <= part_en_s3 ? x_trunc_reg : 20'd0;
            disp_y_reg <= part_en_s3 ? y_trunc_reg : 20'd0;
        end
    end

    assign disp_x = $signed(disp_x_reg);
    assign disp_y = $signed(disp_y_reg);

endmodule

`default_nettype wire

### src/prao_rot_pipe.sv
// Four-stage datapath that builds the 3x3 rotation matrix in signed 4.12.
// Depends on prao_pkg for the stage enables and product slice constants.
`default_nettype none

module prao_rot_pipe
    import prao_pkg::*;
(
    input  wire                aclk,
    input  wire stage_en_t     stage_en,
    input  wire  [31:0]        trig_x,
    input  wire  [31:0]        trig_y,
    input  wire  [31:0]        trig_z,
    input  wire                part_en_s3,
    output logic signed [15:0] rot_r0c0,
    output logic signed [15:0] rot_r0c1,
    output logic signed [15:0] rot_r0c2,
    output logic signed [15:0] rot_r1c0,
    output logic signed [15:0] rot_r1c1,
    output logic signed [15:0] rot_r1c2,
    output logic signed [15:0] rot_r2c0,
    output logic signed [15:0] rot_r2c1,
    output logic signed [15:0] rot_r2c2
);

    // Stage 1 registers: sines, cosines and the negated terms.
    logic signed [15:0] sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;
    logic signed [16:0] nsy_reg, nsz_reg, ncy_reg;

    // Stage 2 products.
    logic signed [32:0] a_full, b_full;
    logic signed [31:0] p_czcy, p_szcx, p_czcx, p_szsx, p_czsx, p_cycx;
    logic signed [32:0] p_nszcy, p_ncysx;
    logic signed [20:0] a_reg, b_reg;
    logic [15:0]        t_czcy_reg, t_nszcy_reg, t_szcx_reg, t_czcx_reg;
    logic [15:0]        t_ncysx_reg, t_szsx_reg, t_czsx_reg, t_cycx_reg;
    logic signed [15:0] sx2_reg, cx2_reg;
    logic [15:0]        sy2_reg;

    // Stage 3 second-level products.
    logic signed [36:0] p_asx, p_acx, p_bsx, p_bcx;
    logic [15:0]        m_asx_reg, m_acx_reg, m_bsx_reg, m_bcx_reg;
    logic [15:0]        t_czcy3_reg, t_nszcy3_reg, t_szcx3_reg, t_czcx3_reg;
    logic [15:0]        t_ncysx3_reg, t_szsx3_reg, t_czsx3_reg, t_cycx3_reg;
    logic [15:0]        sy3_reg;

    // Stage 4 output registers.
    logic [15:0] r0c0_reg, r0c1_reg, r0c2_reg;
    logic [15:0] r1c0_reg, r1c1_reg, r1c2_reg;
    logic [15:0] r2c0_reg, r2c1_reg, r2c2_reg;

    // Stage 1: unpack the trig words and form the negated operands.
    always_ff @(posedge aclk) begin
        if (stage_en.ld1) begin
            sx_reg  <= $signed(trig_x[15:0]);
            cx_reg  <= $signed(trig_x[31:16]);
            sy_reg  <= $signed(trig_y[15:0]);
            cy_reg  <= $signed(trig_y[31:16]);
            sz_reg  <= $signed(trig_z[15:0]);
            cz_reg  <= $signed(trig_z[31:16]);
            nsy_reg <= $signed(17'(17'd0 - {trig_y[15], trig_y[15:0]}));
            nsz_reg <= $signed(17'(17'd0 - {trig_z[15], trig_z[15:0]}));
            ncy_reg <= $signed(17'(17'd0 - {trig_y[31], trig_y[31:16]}));
        end
    end

    // Stage 2: first-level products; A and B keep their full floored width.
    assign a_full  = cz_reg * nsy_reg;
    assign b_full  = sz_reg * nsy_reg;
    assign p_czcy  = cz_reg * cy_reg;
    assign p_nszcy = nsz_reg * cy_reg;
    assign p_szcx  = sz_reg * cx_reg;
    assign p_czcx  = cz_reg * cx_reg;
    assign p_ncysx = ncy_reg * sx_reg;
    assign p_szsx  = sz_reg * sx_reg;
    assign p_czsx  = cz_reg * sx_reg;
    assign p_cycx  = cy_reg * cx_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.ld2) begin
            a_reg       <= a_full[32:FRAC_BITS];
            b_reg       <= b_full[32:FRAC_BITS];
            t_czcy_reg  <= p_czcy[PROD_MSB:PROD_LSB];
            t_nszcy_reg <= p_nszcy[PROD_MSB:PROD_LSB];
            t_szcx_reg  <= p_szcx[PROD_MSB:PROD_LSB];
            t_czcx_reg  <= p_czcx[PROD_MSB:PROD_LSB];
            t_ncysx_reg <= p_ncysx[PROD_MSB:PROD_LSB];
            t_szsx_reg  <= p_szsx[PROD_MSB:PROD_LSB];
            t_czsx_reg  <= p_czsx[PROD_MSB:PROD_LSB];
            t_cycx_reg  <= p_cycx[PROD_MSB:PROD_LSB];
            sx2_reg     <= sx_reg;
            cx2_reg     <= cx_reg;
            sy2_reg     <= sy_reg;
        end
    end

    // Stage 3: products of A and B with the x-axis terms.
    assign p_asx = a_reg * sx2_reg;
    assign p_acx = a_reg * cx2_reg;
    assign p_bsx = b_reg * sx2_reg;
    assign p_bcx = b_reg * cx2_reg;

    always_ff @(posedge aclk) begin
        if (stage_en.ld3) begin
            m_asx_reg    <= p_asx[PROD_MSB:PROD_LSB];
            m_acx_reg    <= p_acx[PROD_MSB:PROD_LSB];
            m_bsx_reg    <= p_bsx[PROD_MSB:PROD_LSB];
            m_bcx_reg    <= p_bcx[PROD_MSB:PROD_LSB];
            t_czcy3_reg  <= t_czcy_reg;
            t_nszcy3_reg <= t_nszcy_reg;
            t_szcx3_reg  <= t_szcx_reg;
            t_czcx3_reg  <= t_czcx_reg;
            t_ncysx3_reg <= t_ncysx_reg;
            t_szsx3_reg  <= t_szsx_reg;
            t_czsx3_reg  <= t_czsx_reg;
            t_cycx3_reg  <= t_cycx_reg;
            sy3_reg      <= sy2_reg;
        end
    end

    // Stage 4: 16-bit sums and passed-through terms into the output registers, zero when disabled.
    always_ff @(posedge aclk) begin
        if (stage_en.ld4) begin
            if (part_en_s3) begin
                r0c0_reg <= t_czcy3_reg;
                r0c1_reg <= t_nszcy3_reg;
                r0c2_reg <= sy3_reg;
                r1c0_reg <= t_szcx3_reg - m_asx_reg;
                r1c1_reg <= t_czcx3_reg + m_bsx_reg;
                r1c2_reg <= t_ncysx3_reg;
                r2c0_reg <= m_acx_reg + t_szsx3_reg;
                r2c1_reg <= t_czsx3_reg - m_bcx_reg;
                r2c2_reg <= t_cycx3_reg;
            end else begin
                r0c0_reg <= '0;
                r0c1_reg <= '0;
                r0c2_reg <= '0;
                r1c0_reg <= '0;
                r1c1_reg <= '0;
                r1c2_reg <= '0;
                r2c0_reg <= '0;
                r2c1_reg <= '0;
                r2c2_reg <= '0;
            end
        end
    end

    assign rot_r0c0 = $signed(r0c0_reg);
    assign rot_r0c1 = $signed(r0c1_reg);
    assign rot_r0c2 = $signed(r0c2_reg);
    assign rot_r1c0 = $signed(r1c0_reg);
    assign rot_r1c1 = $signed(r1c1_reg);
    assign rot_r1c2 = $signed(r1c2_reg);
    assign rot_r2c0 = $signed(r2c0_reg);
    assign rot_r2c1 = $signed(r2c1_reg);
    assign rot_r2c2 = $signed(r2c2_reg);

endmodule

`default_nettype wire

### src/part_rotation_and_offset_top.sv
// Top level of the part rotation and offset pipeline: valid tracking and handshakes.
// Depends on prao_pkg, prao_offset_pipe and prao_rot_pipe.
//
// Each input beat describes one sprite part and yields exactly one result beat,
// valid on the result ports once it has passed through the pipeline: the
// enable flag, the two scaled offsets and the 3x3 rotation matrix in signed
// 4.12. The pipeline has four register stages (operand prep, first multiply,
// second multiply, sum and output register), each with its own valid bit, so one
// beat is accepted every cycle unless the pipeline stalls. A stage loads whenever
// it is empty or the stage after it moves, so s_ready stays high while the output
// holds a result and any stage is empty; the pipeline stalls only when all four
// stages are full and m_ready is low. The block keeps no state between parts.
`default_nettype none

module part_rotation_and_offset_top
    import prao_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,

    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [15:0]        s_offset_pair,
    input  wire  [15:0]        s_angle_z_word,
    input  wire  [31:0]        s_trig_x,
    input  wire  [31:0]        s_trig_y,
    input  wire  [31:0]        s_trig_z,
    input  wire  signed [15:0] s_actor_scale,
    input  wire  [4:0]         s_ofs_shift,
    input  wire                s_mirror_x,

    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_part_enabled,
    output logic signed [19:0] m_disp_x,
    output logic signed [19:0] m_disp_y,
    output logic signed [15:0] m_rot_r0c0,
    output logic signed [15:0] m_rot_r0c1,
    output logic signed [15:0] m_rot_r0c2,
    output logic signed [15:0] m_rot_r1c0,
    output logic signed [15:0] m_rot_r1c1,
    output logic signed [15:0] m_rot_r1c2,
    output logic signed [15:0] m_rot_r2c0,
    output logic signed [15:0] m_rot_r2c1,
    output logic signed [15:0] m_rot_r2c2
);

    stage_en_t stage_en;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic pe1_reg, pe2_reg, pe3_reg, pe4_reg;

    // Per-stage load enables: a stage moves when it is empty or its successor moves.
    always_comb begin
        stage_en.ld4 = !v4_reg || m_ready;
        stage_en.ld3 = !v3_reg || stage_en.ld4;
        stage_en.ld2 = !v2_reg || stage_en.ld3;
        stage_en.ld1 = !v1_reg || stage_en.ld2;
    end

    assign s_ready = stage_en.ld1;

    // Valid bits travel with the data through the four stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (stage_en.ld1) begin
                v1_reg <= s_valid;
            end
            if (stage_en.ld2) begin
                v2_reg <= v1_reg;
            end
            if (stage_en.ld3) begin
                v3_reg <= v2_reg;
            end
            if (stage_en.ld4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // The part is enabled when the offset pair or the angle word is nonzero.
    always_ff @(posedge aclk) begin
        if (stage_en.ld1) begin
            pe1_reg <= (s_offset_pair != 16'd0) || (s_angle_z_word != 16'd0);
        end
        if (stage_en.ld2) begin
            pe2_reg <= pe1_reg;
        end
        if (stage_en.ld3) begin
            pe3_reg <= pe2_reg;
        end
        if (stage_en.ld4) begin
            pe4_reg <= pe3_reg;
        end
    end

    assign m_valid        = v4_reg;
    assign m_part_enabled = pe4_reg;

    // Scaled offset datapath.
    prao_offset_pipe u_offset (
        .aclk        (aclk),
        .stage_en    (stage_en),
        .offset_pair (s_offset_pair),
        .actor_scale (s_actor_scale),
        .ofs_shift   (s_ofs_shift),
        .mirror_x    (s_mirror_x),
        .part_en_s3  (pe3_reg),
        .disp_x      (m_disp_x),
        .disp_y      (m_disp_y)
    );

    // Rotation matrix datapath.
    prao_rot_pipe u_rot (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .trig_x     (s_trig_x),
        .trig_y     (s_trig_y),
        .trig_z     (s_trig_z),
        .part_en_s3 (pe3_reg),
        .rot_r0c0   (m_rot_r0c0),
        .rot_r0c1   (m_rot_r0c1),
        .rot_r0c2   (m_rot_r0c2),
        .rot_r1c0   (m_rot_r1c0),
        .rot_r1c1   (m_rot_r1c1),
        .rot_r1c2   (m_rot_r1c2),
        .rot_r2c0   (m_rot_r2c0),
        .rot_r2c1   (m_rot_r2c1),
        .rot_r2c2   (m_rot_r2c2)
    );

endmodule

`default_nettype wire
